// ----- hdl/sac_pkg.sv -----
// ----------------------------------------------------------------------------
// sac_pkg
// Shared widths, calibration constants and register indexes of the steering
// angle calibrator.
// ----------------------------------------------------------------------------
package sac_pkg;

   // sample and angle fields
   localparam int RAW_W    = 16;
   localparam int ANGLE_W  = 15;
   localparam int FAULT_W  = 8;

   // calibration constants
   localparam int MAX_ANGLE_DEG = 45;
   localparam int FAULT_LIMIT   = 3;
   localparam int FRACTION_BITS = 8;

   localparam int FULL_SCALE = MAX_ANGLE_DEG * (1 << FRACTION_BITS);
   localparam int FS_W       = $clog2(FULL_SCALE + 1);

   // internal signed angle, wide enough for the full scale and the output field
   localparam int ANG_W  = (FS_W + 1 > ANGLE_W) ? FS_W + 1 : ANGLE_W;
   // raw difference magnitude and span magnitude
   localparam int DIFF_W = RAW_W + 1;
   // dividend of the angle division
   localparam int PROD_W = DIFF_W + FS_W;
   localparam int DIV_CNT_W = $clog2(PROD_W + 1);

   // configuration port
   localparam int CSR_IDX_W = 4;
   localparam int NUM_REGS  = 8;
   // slot select into the register file
   localparam int CFG_IDX_W = $clog2(NUM_REGS);

   localparam logic [CSR_IDX_W-1:0] REG_LEFT_MIN     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_CENTER  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_MAX     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_MIN    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_CENTER = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_MAX    = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_SANE_LOW     = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_SANE_HIGH    = CSR_IDX_W'(7);

   localparam logic signed [RAW_W-1:0] RST_MIN    = RAW_W'(0);
   localparam logic signed [RAW_W-1:0] RST_CENTER = RAW_W'(13200);
   localparam logic signed [RAW_W-1:0] RST_MAX    = RAW_W'(26400);
   localparam logic signed [RAW_W-1:0] RST_LOW    = RAW_W'(-32768);
   localparam logic signed [RAW_W-1:0] RST_HIGH   = RAW_W'(32767);

endpackage

// ----- hdl/sac_req_if.sv -----
// ----------------------------------------------------------------------------
// sac_req_if
// Request channel carrying two potentiometer samples and the read flag.
// ----------------------------------------------------------------------------
interface sac_req_if import sac_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [RAW_W-1:0] raw_left;
   logic signed [RAW_W-1:0] raw_right;
   logic                    read_ok;

   modport source (output valid, raw_left, raw_right, read_ok, input ready);
   modport sink   (input valid, raw_left, raw_right, read_ok, output ready);
endinterface

// ----- hdl/sac_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sac_rsp_if
// Result channel carrying the calibrated angles and status flags.
// ----------------------------------------------------------------------------
interface sac_rsp_if import sac_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] angle_left;
   logic signed [ANGLE_W-1:0] angle_right;
   logic signed [ANGLE_W-1:0] mean_angle;
   logic                      valid_res;
   logic                      healthy;

   modport source (output valid, angle_left, angle_right, mean_angle, valid_res, healthy,
                   input ready);
   modport sink   (input valid, angle_left, angle_right, mean_angle, valid_res, healthy,
                   output ready);
endinterface

// ----- hdl/sac_csr_if.sv -----
// ----------------------------------------------------------------------------
// sac_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sac_csr_if import sac_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [RAW_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/sac_divider.sv -----
// ----------------------------------------------------------------------------
// sac_divider
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sac_divider import sac_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] dividend,
   input  logic [DIFF_W-1:0] divisor,
   output logic              done,
   output logic [PROD_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [DIFF_W-1:0]    rem_ff, rem_in;
   logic [DIFF_W:0]      trial;
   logic                 fits;

   // dividend bits leave at the top while quotient bits enter at the bottom
   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(PROD_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[PROD_W-2:0], fits};
         rem_in = fits ? DIFF_W'(trial - {1'b0, divisor}) : trial[DIFF_W-1:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hdl/steering_angle_calibrator.sv -----
// ----------------------------------------------------------------------------
// steering_angle_calibrator
// Three-point piecewise-linear calibration of two steering potentiometers
// with plausibility checks and a saturating fault counter.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus : one request per sample pair (raw_left, raw_right, read_ok).
//   rsp_bus : one result per request (angles in 1/256 degree, mean, flags).
//   csr_bus : register writes, always ready; write only while the block idles.
// A request is taken only in the idle state. A faulty request (read failure
// or a sample outside the sanity window) goes from the idle state straight
// to the done state, where its result is registered. A good request runs
// both sides in turn through one shared bit-serial divider (setup, load,
// PROD_W steps, quotient pick-up per side): its result is registered in the
// done state, and the next request is taken once the block is back in idle.
// The result register frees the block, so a new request is taken while an
// earlier result waits; behind a stalled receiver the next finished request
// holds in its last state until the register is free.
// Reset loads the calibration defaults, clears the fault state, raises health.
// ----------------------------------------------------------------------------
module steering_angle_calibrator import sac_pkg::*; (
   input  logic clock,
   input  logic reset,
   sac_req_if.sink   req_bus,
   sac_rsp_if.source rsp_bus,
   sac_csr_if.sink   csr_bus
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       side_ff, side_in;

   logic signed [RAW_W-1:0] cfg_ff [NUM_REGS];

   logic signed [RAW_W-1:0] raw_l_ff, raw_r_ff;
   logic                    good_ff, good_in;
   logic [DIFF_W-1:0]       diff_ff, diff_in;
   logic [DIFF_W-1:0]       vmag_ff, vmag_in;
   logic                    neg_ff, neg_in;
   logic                    zero_ff, zero_in;
   logic signed [ANG_W-1:0] angle_l_ff, angle_l_in;
   logic signed [ANG_W-1:0] angle_r_ff, angle_r_in;

   logic [FAULT_W-1:0]        fault_ff, fault_in;
   logic                      health_ff, health_in;
   logic signed [ANGLE_W-1:0] held_l_ff, held_l_in;
   logic signed [ANGLE_W-1:0] held_r_ff, held_r_in;
   logic signed [ANGLE_W-1:0] held_m_ff, held_m_in;
   logic                      held_v_ff, held_v_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_W-1:0] rsp_l_ff, rsp_l_in;
   logic signed [ANGLE_W-1:0] rsp_r_ff, rsp_r_in;
   logic signed [ANGLE_W-1:0] rsp_m_ff, rsp_m_in;
   logic                      rsp_v_ff, rsp_v_in;
   logic                      rsp_h_ff, rsp_h_in;

   logic req_take, out_free;
   logic l_sane, r_sane;

   logic signed [RAW_W-1:0]  sel_raw, sel_lo, sel_mid, sel_hi;
   logic signed [DIFF_W-1:0] raw_x, lo_x, mid_x, hi_x, span;
   logic                     below;

   logic              div_start, div_done;
   logic [PROD_W-1:0] div_dividend, div_quotient;
   logic [FS_W-1:0]   mag;
   logic signed [ANG_W-1:0] angle_new;

   logic signed [ANG_W:0]   sum;
   logic signed [ANG_W:0]   mean;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign l_sane = (req_bus.raw_left >= cfg_ff[CFG_IDX_W'(REG_SANE_LOW)])
                && (req_bus.raw_left <= cfg_ff[CFG_IDX_W'(REG_SANE_HIGH)]);
   assign r_sane = (req_bus.raw_right >= cfg_ff[CFG_IDX_W'(REG_SANE_LOW)])
                && (req_bus.raw_right <= cfg_ff[CFG_IDX_W'(REG_SANE_HIGH)]);

   // per-side operand selection
   always_comb begin
      if (side_ff) begin
         sel_raw = raw_r_ff;
         sel_lo  = cfg_ff[CFG_IDX_W'(REG_RIGHT_MIN)];
         sel_mid = cfg_ff[CFG_IDX_W'(REG_RIGHT_CENTER)];
         sel_hi  = cfg_ff[CFG_IDX_W'(REG_RIGHT_MAX)];
      end else begin
         sel_raw = raw_l_ff;
         sel_lo  = cfg_ff[CFG_IDX_W'(REG_LEFT_MIN)];
         sel_mid = cfg_ff[CFG_IDX_W'(REG_LEFT_CENTER)];
         sel_hi  = cfg_ff[CFG_IDX_W'(REG_LEFT_MAX)];
      end
      raw_x = DIFF_W'(sel_raw);
      lo_x  = DIFF_W'(sel_lo);
      mid_x = DIFF_W'(sel_mid);
      hi_x  = DIFF_W'(sel_hi);
      below = (sel_raw < sel_mid);
      span  = below ? (mid_x - lo_x) : (hi_x - mid_x);
   end

   assign div_dividend = PROD_W'(diff_ff) * PROD_W'(FULL_SCALE);
   assign div_start    = (state_ff == S_START);

   sac_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (vmag_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // clamp to full scale, then apply the sign
   always_comb begin
      if (div_quotient > PROD_W'(FULL_SCALE)) begin
         mag = FS_W'(FULL_SCALE);
      end else begin
         mag = div_quotient[FS_W-1:0];
      end
      if (zero_ff) begin
         angle_new = '0;
      end else if (neg_ff) begin
         angle_new = -$signed(ANG_W'(mag));
      end else begin
         angle_new = $signed(ANG_W'(mag));
      end
   end

   // floored mean of the full-width angles
   assign sum  = (ANG_W + 1)'(angle_l_ff) + (ANG_W + 1)'(angle_r_ff);
   assign mean = sum >>> 1;

   always_comb begin
      state_in   = state_ff;
      side_in    = side_ff;
      good_in    = good_ff;
      diff_in    = diff_ff;
      vmag_in    = vmag_ff;
      neg_in     = neg_ff;
      zero_in    = zero_ff;
      angle_l_in = angle_l_ff;
      angle_r_in = angle_r_ff;
      fault_in   = fault_ff;
      health_in  = health_ff;
      held_l_in  = held_l_ff;
      held_r_in  = held_r_ff;
      held_m_in  = held_m_ff;
      held_v_in  = held_v_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_l_in   = rsp_l_ff;
      rsp_r_in   = rsp_r_ff;
      rsp_m_in   = rsp_m_ff;
      rsp_v_in   = rsp_v_ff;
      rsp_h_in   = rsp_h_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               good_in  = req_bus.read_ok && l_sane && r_sane;
               side_in  = 1'b0;
               state_in = (req_bus.read_ok && l_sane && r_sane) ? S_SETUP : S_DONE;
            end
         end
         S_SETUP: begin
            diff_in  = below ? DIFF_W'(mid_x - raw_x) : DIFF_W'(raw_x - mid_x);
            vmag_in  = span[DIFF_W-1] ? DIFF_W'(-span) : DIFF_W'(span);
            neg_in   = below ^ span[DIFF_W-1];
            zero_in  = (span == '0);
            state_in = S_START;
         end
         S_START: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_done) begin
               if (side_ff) begin
                  angle_r_in = angle_new;
                  state_in   = S_DONE;
               end else begin
                  angle_l_in = angle_new;
                  side_in    = 1'b1;
                  state_in   = S_SETUP;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (good_ff) begin
                  fault_in  = '0;
                  health_in = 1'b1;
                  held_l_in = angle_l_ff[ANGLE_W-1:0];
                  held_r_in = angle_r_ff[ANGLE_W-1:0];
                  held_m_in = mean[ANGLE_W-1:0];
                  held_v_in = 1'b1;
                  rsp_l_in  = angle_l_ff[ANGLE_W-1:0];
                  rsp_r_in  = angle_r_ff[ANGLE_W-1:0];
                  rsp_m_in  = mean[ANGLE_W-1:0];
                  rsp_v_in  = 1'b1;
                  rsp_h_in  = 1'b1;
               end else begin
                  if (fault_ff < FAULT_W'(FAULT_LIMIT)) begin
                     fault_in = fault_ff + FAULT_W'(1);
                  end
                  if (fault_in >= FAULT_W'(FAULT_LIMIT)) begin
                     // persistent failure
                     health_in = 1'b0;
                     held_v_in = 1'b0;
                     rsp_l_in  = '0;
                     rsp_r_in  = '0;
                     rsp_m_in  = '0;
                     rsp_v_in  = 1'b0;
                     rsp_h_in  = 1'b0;
                  end else begin
                     rsp_l_in  = held_l_ff;
                     rsp_r_in  = held_r_ff;
                     rsp_m_in  = held_m_ff;
                     rsp_v_in  = held_v_ff;
                     rsp_h_in  = health_ff;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         side_ff      <= 1'b0;
         fault_ff     <= '0;
         health_ff    <= 1'b1;
         held_l_ff    <= '0;
         held_r_ff    <= '0;
         held_m_ff    <= '0;
         held_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         fault_ff     <= fault_in;
         health_ff    <= health_in;
         held_l_ff    <= held_l_in;
         held_r_ff    <= held_r_in;
         held_m_ff    <= held_m_in;
         held_v_ff    <= held_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         raw_l_ff <= req_bus.raw_left;
         raw_r_ff <= req_bus.raw_right;
      end
      good_ff    <= good_in;
      diff_ff    <= diff_in;
      vmag_ff    <= vmag_in;
      neg_ff     <= neg_in;
      zero_ff    <= zero_in;
      angle_l_ff <= angle_l_in;
      angle_r_ff <= angle_r_in;
      rsp_l_ff   <= rsp_l_in;
      rsp_r_ff   <= rsp_r_in;
      rsp_m_ff   <= rsp_m_in;
      rsp_v_ff   <= rsp_v_in;
      rsp_h_ff   <= rsp_h_in;
   end

   // calibration registers, writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CFG_IDX_W'(REG_LEFT_MIN)]     <= RST_MIN;
         cfg_ff[CFG_IDX_W'(REG_LEFT_CENTER)]  <= RST_CENTER;
         cfg_ff[CFG_IDX_W'(REG_LEFT_MAX)]     <= RST_MAX;
         cfg_ff[CFG_IDX_W'(REG_RIGHT_MIN)]    <= RST_MIN;
         cfg_ff[CFG_IDX_W'(REG_RIGHT_CENTER)] <= RST_CENTER;
         cfg_ff[CFG_IDX_W'(REG_RIGHT_MAX)]    <= RST_MAX;
         cfg_ff[CFG_IDX_W'(REG_SANE_LOW)]     <= RST_LOW;
         cfg_ff[CFG_IDX_W'(REG_SANE_HIGH)]    <= RST_HIGH;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            REG_LEFT_MIN:     cfg_ff[CFG_IDX_W'(REG_LEFT_MIN)]     <= csr_bus.data;
            REG_LEFT_CENTER:  cfg_ff[CFG_IDX_W'(REG_LEFT_CENTER)]  <= csr_bus.data;
            REG_LEFT_MAX:     cfg_ff[CFG_IDX_W'(REG_LEFT_MAX)]     <= csr_bus.data;
            REG_RIGHT_MIN:    cfg_ff[CFG_IDX_W'(REG_RIGHT_MIN)]    <= csr_bus.data;
            REG_RIGHT_CENTER: cfg_ff[CFG_IDX_W'(REG_RIGHT_CENTER)] <= csr_bus.data;
            REG_RIGHT_MAX:    cfg_ff[CFG_IDX_W'(REG_RIGHT_MAX)]    <= csr_bus.data;
            REG_SANE_LOW:     cfg_ff[CFG_IDX_W'(REG_SANE_LOW)]     <= csr_bus.data;
            REG_SANE_HIGH:    cfg_ff[CFG_IDX_W'(REG_SANE_HIGH)]    <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.angle_left  = rsp_l_ff;
   assign rsp_bus.angle_right = rsp_r_ff;
   assign rsp_bus.mean_angle  = rsp_m_ff;
   assign rsp_bus.valid_res   = rsp_v_ff;
   assign rsp_bus.healthy     = rsp_h_ff;

endmodule
